// ----- sv/dadsi_pkg.sv -----
// Shared types and constants for the dual-axis drive safety interlock.
`default_nettype none

package dadsi_pkg;

  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 16;

  // Configuration register indexes.
  localparam logic [CfgIdxW-1:0] RegRemoteTimeout = 3'd0;
  localparam logic [CfgIdxW-1:0] RegRangeTimeout  = 3'd1;
  localparam logic [CfgIdxW-1:0] RegLatHighMax    = 3'd2;
  localparam logic [CfgIdxW-1:0] RegLatLowMin     = 3'd3;
  localparam logic [CfgIdxW-1:0] RegVertHighMax   = 3'd4;
  localparam logic [CfgIdxW-1:0] RegVertLowMin    = 3'd5;
  localparam logic [CfgIdxW-1:0] RegNeutralBand   = 3'd6;
  localparam logic [CfgIdxW-1:0] RegShellEnable   = 3'd7;

  // Reset values of the configuration registers.
  localparam logic [15:0] RemoteTimeoutRst = 16'd100;
  localparam logic [7:0]  RangeTimeoutRst  = 8'd10;
  localparam logic [15:0] HighMaxRst       = 16'hFFFF;
  localparam logic [15:0] LowMinRst        = 16'h0000;
  localparam logic [15:0] NeutralBandRst   = 16'd512;
  localparam logic        ShellEnableRst   = 1'b1;

  localparam logic [7:0]  RunMax     = 8'hFF;
  localparam logic [15:0] SilenceMax = 16'hFFFF;

  typedef struct packed {
    logic        user_enable;
    logic [7:0]  mode;
    logic        message_seen;
    logic [15:0] lat_sample;
    logic [15:0] vert_sample;
    logic [15:0] lat_actual;
    logic [15:0] lat_desired;
    logic [15:0] vert_actual;
    logic [15:0] vert_desired;
  } in_item_t;

  typedef struct packed {
    logic drive_enabled;
    logic watchdog_level;
    logic lat_interlocked;
    logic vert_interlocked;
    logic fault_indicator;
  } out_item_t;

  // Limits for one axis.
  typedef struct packed {
    logic [15:0] high_max;
    logic [15:0] low_min;
    logic [15:0] neutral_band;
  } axis_cfg_t;

  // Updated run counters and band status for one axis.
  typedef struct packed {
    logic [7:0] high_run;
    logic [7:0] low_run;
    logic       in_band;
  } axis_stat_t;

endpackage

`default_nettype wire

// ----- sv/dadsi_axis.sv -----
// Range run counters and neutral band check for one drive axis.
`default_nettype none

module dadsi_axis
  import dadsi_pkg::*;
(
  input  wire logic       clear_i,
  input  wire logic [15:0] sample_i,
  input  wire logic [15:0] actual_i,
  input  wire logic [15:0] desired_i,
  input  wire logic [7:0]  high_run_i,
  input  wire logic [7:0]  low_run_i,
  input  wire axis_cfg_t   cfg_i,
  output axis_stat_t       stat_o
);

  logic [7:0]  high_base;
  logic [7:0]  low_base;
  logic [7:0]  high_inc;
  logic [7:0]  low_inc;
  logic [15:0] err;

  // With clear_i set (user or shell disabled) the runs start again from zero in this tick.
  assign high_base = clear_i ? '0 : high_run_i;
  assign low_base  = clear_i ? '0 : low_run_i;
  assign high_inc  = (high_base == RunMax) ? RunMax : high_base + 8'd1;
  assign low_inc   = (low_base == RunMax) ? RunMax : low_base + 8'd1;

  assign err = (actual_i >= desired_i) ? actual_i - desired_i : desired_i - actual_i;

  always_comb begin
    stat_o.high_run = '0;
    stat_o.low_run  = '0;
    stat_o.in_band  = (err < cfg_i.neutral_band);
    if (sample_i >= cfg_i.high_max) begin
      stat_o.high_run = high_inc;
    end else if (sample_i <= cfg_i.low_min) begin
      stat_o.low_run = low_inc;
    end
  end

endmodule

`default_nettype wire

// ----- sv/dual_axis_drive_safety_interlock.sv -----
// Top level of the dual-axis drive safety interlock.
//
//   channel  signals                          direction
//   in       in_valid_i/in_ready_o/in_data_i  one control tick
//   out      out_valid_o/out_ready_i/out_data_o  one status result
//   cfg      cfg_we_i/cfg_idx_i/cfg_data_i    register write, no wait
//
// The state update and the result are computed from the input port in
// one pass and land in the result register.
// A new tick is taken in every cycle in which the result register is empty
// or its transfer completes, so stalls on the output back up one item only.
// Reset clears the tick state and loads the register defaults; the result data register is not reset.
`default_nettype none

module dual_axis_drive_safety_interlock
  import dadsi_pkg::*;
(
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                in_valid_i,
  output logic                     in_ready_o,
  input  wire in_item_t            in_data_i,
  output logic                     out_valid_o,
  input  wire logic                out_ready_i,
  output out_item_t                out_data_o,
  input  wire logic                cfg_we_i,
  input  wire logic [CfgIdxW-1:0]  cfg_idx_i,
  input  wire logic [CfgDataW-1:0] cfg_data_i
);

  // Configuration registers.
  logic [15:0] remote_timeout_q;
  logic [7:0]  range_timeout_q;
  logic [15:0] lat_high_max_q, lat_low_min_q;
  logic [15:0] vert_high_max_q, vert_low_min_q;
  logic [15:0] neutral_band_q;
  logic        shell_enable_q;

  // Tick state.
  logic [15:0] silence_q, silence_d;
  logic [7:0]  lat_high_q, lat_low_q, vert_high_q, vert_low_q;
  logic [7:0]  prev_mode_q;
  logic        lat_lock_q, lat_lock_d, vert_lock_q, vert_lock_d;
  logic        wd_div_q, wd_div_d, wd_level_q, wd_level_d;

  logic        out_valid_q;
  out_item_t   out_q, out_d;

  logic        in_fire;
  logic        user_ok;
  logic        range_fault;
  logic        approve;
  logic [15:0] silence_base;
  axis_cfg_t   lat_cfg, vert_cfg;
  axis_stat_t  lat_stat, vert_stat;

  assign in_ready_o  = !out_valid_q || out_ready_i;
  assign in_fire     = in_valid_i && in_ready_o;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      remote_timeout_q <= RemoteTimeoutRst;
      range_timeout_q  <= RangeTimeoutRst;
      lat_high_max_q   <= HighMaxRst;
      lat_low_min_q    <= LowMinRst;
      vert_high_max_q  <= HighMaxRst;
      vert_low_min_q   <= LowMinRst;
      neutral_band_q   <= NeutralBandRst;
      shell_enable_q   <= ShellEnableRst;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        RegRemoteTimeout: remote_timeout_q <= cfg_data_i;
        RegRangeTimeout:  range_timeout_q  <= cfg_data_i[7:0];
        RegLatHighMax:    lat_high_max_q   <= cfg_data_i;
        RegLatLowMin:     lat_low_min_q    <= cfg_data_i;
        RegVertHighMax:   vert_high_max_q  <= cfg_data_i;
        RegVertLowMin:    vert_low_min_q   <= cfg_data_i;
        RegNeutralBand:   neutral_band_q   <= cfg_data_i;
        RegShellEnable:   shell_enable_q   <= cfg_data_i[0];
        default: begin
        end
      endcase
    end
  end

  // Remote silence counter: a message restarts it, then it counts on
  // until it has passed the timeout.
  assign silence_base = in_data_i.message_seen ? '0 : silence_q;
  assign silence_d    = (silence_base <= remote_timeout_q && silence_base != SilenceMax)
                        ? silence_base + 16'd1 : silence_base;

  assign user_ok = in_data_i.user_enable && shell_enable_q;

  assign lat_cfg  = '{high_max: lat_high_max_q, low_min: lat_low_min_q,
                      neutral_band: neutral_band_q};
  assign vert_cfg = '{high_max: vert_high_max_q, low_min: vert_low_min_q,
                      neutral_band: neutral_band_q};

  dadsi_axis u_lat (
    .clear_i    (!user_ok),
    .sample_i   (in_data_i.lat_sample),
    .actual_i   (in_data_i.lat_actual),
    .desired_i  (in_data_i.lat_desired),
    .high_run_i (lat_high_q),
    .low_run_i  (lat_low_q),
    .cfg_i      (lat_cfg),
    .stat_o     (lat_stat)
  );

  dadsi_axis u_vert (
    .clear_i    (!user_ok),
    .sample_i   (in_data_i.vert_sample),
    .actual_i   (in_data_i.vert_actual),
    .desired_i  (in_data_i.vert_desired),
    .high_run_i (vert_high_q),
    .low_run_i  (vert_low_q),
    .cfg_i      (vert_cfg),
    .stat_o     (vert_stat)
  );

  assign range_fault = (lat_stat.high_run > range_timeout_q) ||
                       (lat_stat.low_run > range_timeout_q) ||
                       (vert_stat.high_run > range_timeout_q) ||
                       (vert_stat.low_run > range_timeout_q);

  assign approve = user_ok && !range_fault && (silence_d < remote_timeout_q);

  always_comb begin
    wd_div_d    = wd_div_q;
    wd_level_d  = wd_level_q;
    lat_lock_d  = lat_lock_q;
    vert_lock_d = vert_lock_q;
    if (approve) begin
      wd_div_d = !wd_div_q;
      if (wd_div_q) begin
        wd_level_d = !wd_level_q;
      end
      if (in_data_i.mode != prev_mode_q) begin
        lat_lock_d  = 1'b1;
        vert_lock_d = 1'b1;
      end
    end else begin
      lat_lock_d  = 1'b1;
      vert_lock_d = 1'b1;
    end
    // A locked axis releases as soon as its position error is in the band.
    if (lat_stat.in_band) begin
      lat_lock_d = 1'b0;
    end
    if (vert_stat.in_band) begin
      vert_lock_d = 1'b0;
    end
  end

  always_comb begin
    out_d.drive_enabled    = approve;
    out_d.watchdog_level   = wd_level_d;
    out_d.lat_interlocked  = lat_lock_d;
    out_d.vert_interlocked = vert_lock_d;
    out_d.fault_indicator  = !approve;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      silence_q   <= '0;
      lat_high_q  <= '0;
      lat_low_q   <= '0;
      vert_high_q <= '0;
      vert_low_q  <= '0;
      prev_mode_q <= '0;
      lat_lock_q  <= 1'b0;
      vert_lock_q <= 1'b0;
      wd_div_q    <= 1'b0;
      wd_level_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_fire) begin
        silence_q   <= silence_d;
        lat_high_q  <= lat_stat.high_run;
        lat_low_q   <= lat_stat.low_run;
        vert_high_q <= vert_stat.high_run;
        vert_low_q  <= vert_stat.low_run;
        prev_mode_q <= in_data_i.mode;
        lat_lock_q  <= lat_lock_d;
        vert_lock_q <= vert_lock_d;
        wd_div_q    <= wd_div_d;
        wd_level_q  <= wd_level_d;
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      out_q <= out_d;
    end
  end

  // An approved tick never leaves the silence count at or past the timeout.
  a_approve_silence: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire && approve |=> silence_q < $past(remote_timeout_q))
    else $error("approved tick with remote timed out");

  // The watchdog only moves on approved ticks.
  a_wd_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire && !approve |=> wd_level_q == $past(wd_level_q) && wd_div_q == $past(wd_div_q))
    else $error("watchdog moved without approval");

  // The reported interlock flags match the stored lock state.
  a_lock_report: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> out_q.lat_interlocked == lat_lock_q && out_q.vert_interlocked == vert_lock_q)
    else $error("interlock flags differ from lock state");

  // An empty result register always lets the next tick in.
  a_ready_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_q |-> in_ready_o)
    else $error("input stalled with empty result register");

endmodule

`default_nettype wire
